@@ design/mal_pkg.sv @@
// Package for the MIDI ACIA loopback block: operation codes, status bits,
// control masks, routing codes, register indexes and shared structs.
// No dependencies; the other design files, apart from mal_if, refer to it by scoped names.
package mal_pkg;

  // Operation codes carried by an input beat.
  localparam logic [2:0] OP_RD_STATUS = 3'd0;
  localparam logic [2:0] OP_RD_DATA   = 3'd1;
  localparam logic [2:0] OP_WR_CTRL   = 3'd2;
  localparam logic [2:0] OP_WR_DATA   = 3'd3;
  localparam logic [2:0] OP_RX_BYTE   = 3'd4;
  localparam logic [2:0] OP_TICK      = 3'd5;

  // Status register bits.
  localparam logic [7:0] ST_IRQ  = 8'h80;
  localparam logic [7:0] ST_TDRE = 8'h02;
  localparam logic [7:0] ST_RDRF = 8'h01;

  // Control register fields.
  localparam logic [7:0] CTRL_RX_IE      = 8'h80;
  localparam logic [7:0] CTRL_TX_MASK    = 8'h60;
  localparam logic [7:0] CTRL_TX_IE_CODE = 8'h20;
  localparam logic [7:0] CTRL_MR_MASK    = 8'h03;

  // Transmit routing codes; the unused code drops the byte.
  localparam logic [1:0] ROUTE_DROP = 2'd0;
  localparam logic [1:0] ROUTE_OUT  = 2'd1;
  localparam logic [1:0] ROUTE_LOOP = 2'd2;

  // Configuration register indexes.
  localparam logic REG_TX_ROUTE  = 1'b0;
  localparam logic REG_TX_CYCLES = 1'b1;

  localparam logic [15:0] TX_CYCLES_RESET = 16'd2560;
  localparam int          RX_DEPTH_DEF    = 2;

  // Decoded command from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic rd_status;
    logic rd_data;
    logic wr_ctrl;
    logic wr_data;
    logic rx_byte;
    logic tick;
  } cmd_t;

  // Configuration write toward the datapath.
  typedef struct packed {
    logic        en;
    logic        idx;
    logic [15:0] data;
  } cfg_wr_t;

endpackage

@@ design/mal_if.sv @@
// Valid/ready channel interfaces for the input and result beats.
// Depends on nothing but the field widths of the block.
interface mal_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink (input valid, input operation, input data_in, output ready);
endinterface

interface mal_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_line;
  logic       tx_valid;
  logic [7:0] tx_byte;

  modport source (output valid, output read_data, output irq_line, output tx_valid,
                  output tx_byte, input ready);
  modport sink (input valid, input read_data, input irq_line, input tx_valid,
                input tx_byte, output ready);
endinterface

@@ design/mal_ctrl.sv @@
// Handshake controller: tracks the result register and decodes operations.
// Depends on mal_pkg for operation codes and the command struct.
module mal_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [2:0]    in_operation,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output mal_pkg::cmd_t cmd
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  assign in_ready  = (state_r == ST_EMPTY) || out_ready;
  assign out_valid = (state_r == ST_FULL);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: if (accept) state_nxt = ST_FULL;
      ST_FULL:  if (out_ready && !accept) state_nxt = ST_EMPTY;
      default:  state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_EMPTY;
    else        state_r <= state_nxt;
  end

  always_comb begin
    cmd           = '0;
    cmd.exec      = accept;
    unique case (in_operation)
      mal_pkg::OP_RD_STATUS: cmd.rd_status = accept;
      mal_pkg::OP_RD_DATA:   cmd.rd_data   = accept;
      mal_pkg::OP_WR_CTRL:   cmd.wr_ctrl   = accept;
      mal_pkg::OP_WR_DATA:   cmd.wr_data   = accept;
      mal_pkg::OP_RX_BYTE:   cmd.rx_byte   = accept;
      mal_pkg::OP_TICK:      cmd.tick      = accept;
      default:               cmd.tick      = 1'b0;
    endcase
  end

  // An accepted beat always leaves a result waiting in the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  // A result that was not taken is still offered.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped without handshake");

  // At most one operation strobe per command.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.rd_status, cmd.rd_data, cmd.wr_ctrl, cmd.wr_data, cmd.rx_byte,
              cmd.tick}))
    else $error("several operation strobes at once");

endmodule

@@ design/mal_dpath.sv @@
// Datapath: configuration, flags, transmit timer, receive FIFO memory and
// the result register. Depends on mal_pkg for codes and the command structs.
module mal_dpath #(
  parameter int RX_DEPTH = mal_pkg::RX_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mal_pkg::cmd_t    cmd,
  input  logic [7:0]       data_in,
  input  mal_pkg::cfg_wr_t cfg_wr,
  output logic [1:0]       tx_route,
  output logic [15:0]      tx_byte_cycles,
  output logic [7:0]       read_data,
  output logic             irq_line,
  output logic             tx_valid,
  output logic [7:0]       tx_byte
);

  localparam int IDX_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int CNT_W = $clog2(RX_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [1:0]       tx_route_r;
  logic [15:0]      tx_cycles_r;
  logic [7:0]       ctrl_r, ctrl_nxt;
  logic             tx_ie_r, tx_ie_nxt;
  logic             rdrf_r, rdrf_nxt;
  logic             tdre_r, tdre_nxt;
  logic [7:0]       last_r, last_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] head_r, head_nxt, head_inc, wr_idx;
  logic [15:0]      cd_r, cd_nxt;
  logic [7:0]       head_data_r;
  logic [7:0]       fifo_mem [RX_DEPTH];

  logic [7:0]       rd_r, rd_nxt;
  logic             irq_r, irq_nxt;
  logic             txv_r;
  logic [7:0]       txb_r;

  logic             master_reset, pop, push;
  logic [SUM_W-1:0] slot_sum;
  logic [7:0]       status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_route_r  <= mal_pkg::ROUTE_DROP;
      tx_cycles_r <= mal_pkg::TX_CYCLES_RESET;
    end else if (cfg_wr.en) begin
      if (cfg_wr.idx == mal_pkg::REG_TX_ROUTE) tx_route_r  <= cfg_wr.data[1:0];
      else                                     tx_cycles_r <= cfg_wr.data;
    end
  end

  assign tx_route       = tx_route_r;
  assign tx_byte_cycles = tx_cycles_r;

  assign master_reset = cmd.wr_ctrl &&
                        ((data_in & mal_pkg::CTRL_MR_MASK) == mal_pkg::CTRL_MR_MASK);
  assign pop  = cmd.rd_data && (count_r != '0);
  assign push = (cmd.rx_byte || (cmd.wr_data && tx_route_r == mal_pkg::ROUTE_LOOP)) &&
                (count_r < CNT_W'(RX_DEPTH));

  assign head_inc = (head_r == IDX_W'(RX_DEPTH - 1)) ? '0 : head_r + 1'b1;

  // Write slot is head plus count, wrapped once around the depth.
  always_comb begin
    slot_sum = SUM_W'(head_r) + SUM_W'(count_r);
    if (slot_sum >= SUM_W'(RX_DEPTH)) slot_sum = slot_sum - SUM_W'(RX_DEPTH);
    wr_idx = IDX_W'(slot_sum);
  end

  assign status = (tdre_r ? mal_pkg::ST_TDRE : 8'h00) |
                  (rdrf_r ? mal_pkg::ST_RDRF : 8'h00) |
                  (irq_r  ? mal_pkg::ST_IRQ  : 8'h00);

  always_comb begin
    ctrl_nxt  = ctrl_r;
    tx_ie_nxt = tx_ie_r;
    rdrf_nxt  = rdrf_r;
    tdre_nxt  = tdre_r;
    last_nxt  = last_r;
    count_nxt = count_r;
    head_nxt  = head_r;
    cd_nxt    = cd_r;
    if (pop) begin
      last_nxt  = head_data_r;
      head_nxt  = head_inc;
      count_nxt = count_r - 1'b1;
      rdrf_nxt  = (count_r != CNT_W'(1));
    end
    if (push) begin
      count_nxt = count_r + 1'b1;
      rdrf_nxt  = 1'b1;
    end
    if (cmd.wr_ctrl) begin
      ctrl_nxt  = data_in;
      tx_ie_nxt = ((data_in & mal_pkg::CTRL_TX_MASK) == mal_pkg::CTRL_TX_IE_CODE);
    end
    if (master_reset) begin
      rdrf_nxt = 1'b0;
      tdre_nxt = 1'b1;
      cd_nxt   = '0;
    end
    if (cmd.wr_data) begin
      tdre_nxt = 1'b0;
      cd_nxt   = (tx_cycles_r == '0) ? 16'd1 : tx_cycles_r;
    end
    if (cmd.tick && cd_r != '0) begin
      cd_nxt = cd_r - 1'b1;
      if (cd_r == 16'd1) tdre_nxt = 1'b1;
    end
    irq_nxt = (rdrf_nxt && ((ctrl_nxt & mal_pkg::CTRL_RX_IE) != 8'h00)) ||
              (tx_ie_nxt && tdre_nxt);
    if (cmd.rd_status)    rd_nxt = status;
    else if (cmd.rd_data) rd_nxt = last_nxt;
    else                  rd_nxt = 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= '0;
      tx_ie_r <= 1'b0;
      rdrf_r  <= 1'b0;
      tdre_r  <= 1'b1;
      last_r  <= '0;
      count_r <= '0;
      head_r  <= '0;
      cd_r    <= '0;
      irq_r   <= 1'b0;
    end else if (cmd.exec) begin
      ctrl_r  <= ctrl_nxt;
      tx_ie_r <= tx_ie_nxt;
      rdrf_r  <= rdrf_nxt;
      tdre_r  <= tdre_nxt;
      last_r  <= last_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      cd_r    <= cd_nxt;
      irq_r   <= irq_nxt;
    end
  end

  // FIFO memory; the head entry is kept in a register, with a bypass when
  // the slot being written is the new head.
  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_idx] <= data_in;
    head_data_r <= (push && wr_idx == head_nxt) ? data_in : fifo_mem[head_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r  <= rd_nxt;
      txv_r <= cmd.wr_data && (tx_route_r == mal_pkg::ROUTE_OUT);
      txb_r <= (cmd.wr_data && tx_route_r == mal_pkg::ROUTE_OUT) ? data_in : 8'h00;
    end
  end

  assign read_data = rd_r;
  assign irq_line  = irq_r;
  assign tx_valid  = txv_r;
  assign tx_byte   = txb_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RX_DEPTH))
    else $error("FIFO count above depth");

  a_timer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cd_r != '0 |-> !tdre_r)
    else $error("transmitter empty while timer runs");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_data |=> !tdre_r && cd_r != '0)
    else $error("data write did not start the transmitter");

endmodule

@@ design/midi_acia_6850_loopback.sv @@
// Top level of the MIDI ACIA loopback block: APB register decode and the
// controller and datapath. Depends on mal_pkg, mal_if, mal_ctrl and mal_dpath.
//
// A 6850-style ACIA with a small receive FIFO and a transmit busy timer. Each
// input beat is one status read, data read, control write, data write,
// received byte or tick, and produces exactly one result beat. For every beat
// the decode, flag update and FIFO access complete in the cycle it is accepted
// and the result lands in an output register, so the block takes one beat per
// clock as long as the result side keeps up. When a result waits, a new beat
// is still accepted in the cycle the waiting result is taken. The FIFO depth
// is the RX_DEPTH parameter; its storage is a small memory whose oldest entry
// is kept in a register so that a data read returns it immediately. No
// clearing pass is needed after reset. Registers:
// tx_route at byte address 0 (0 drop, 1 send out, 2 loop back) and
// tx_byte_cycles at byte address 4 (ticks the transmitter stays busy).
// Configure only while no beat is in flight.
module midi_acia_6850_loopback #(
  parameter int RX_DEPTH = mal_pkg::RX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mal_in_if.sink      in_bus,
  mal_out_if.source   out_bus,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mal_pkg::cmd_t    cmd;
  mal_pkg::cfg_wr_t cfg_wr;
  logic [1:0]       tx_route;
  logic [15:0]      tx_byte_cycles;

  // APB: writes complete in the access phase, no wait states. Register index
  // comes from address bit 2; the low address bits are ignored.
  assign cfg_pready  = 1'b1;
  assign cfg_wr.en   = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_wr.idx  = cfg_paddr[2];
  assign cfg_wr.data = cfg_pwdata[15:0];

  always_comb begin
    unique case (cfg_paddr[2])
      mal_pkg::REG_TX_ROUTE:  cfg_prdata = {30'b0, tx_route};
      mal_pkg::REG_TX_CYCLES: cfg_prdata = {16'b0, tx_byte_cycles};
      default:                cfg_prdata = '0;
    endcase
  end

  mal_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_bus.valid),
    .in_operation (in_bus.operation),
    .in_ready     (in_bus.ready),
    .out_valid    (out_bus.valid),
    .out_ready    (out_bus.ready),
    .cmd          (cmd)
  );

  mal_dpath #(
    .RX_DEPTH (RX_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .data_in        (in_bus.data_in),
    .cfg_wr         (cfg_wr),
    .tx_route       (tx_route),
    .tx_byte_cycles (tx_byte_cycles),
    .read_data      (out_bus.read_data),
    .irq_line       (out_bus.irq_line),
    .tx_valid       (out_bus.tx_valid),
    .tx_byte        (out_bus.tx_byte)
  );

endmodule
